// File: sv/mixed_radix_index_convert_macros.svh
// Assertion macro used by the index converter's output buffer (mrc_out_buf).
`ifndef MIXED_RADIX_INDEX_CONVERT_MACROS_SVH
`define MIXED_RADIX_INDEX_CONVERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define MRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// File: sv/mrc_pkg.sv
// Constants and types shared by the index converter modules.
`default_nettype none
package mrc_pkg;

  localparam int MaxDims      = 4;
  localparam int SizeBitsDef  = 12;
  localparam int LinBits      = 48;
  localparam int BitsPerStage = 4;
  localparam int StagesPerDim = LinBits / BitsPerStage;
  localparam int PipeDepth    = MaxDims * StagesPerDim;
  localparam int DimW         = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int DimCntW      = $clog2(MaxDims + 1);
  localparam int CfgIdxW      = $clog2(MaxDims + 2);
  localparam int DimsRegW     = 3;

  localparam logic [CfgIdxW-1:0] CfgDimsIdx  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSize0Idx = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgInnerIdx = CfgIdxW'(MaxDims + 1);

  typedef struct packed {
    logic valid;
    logic cmd;    // 1: linear index to coordinates
    logic err;
  } item_ctl_t;

endpackage
`default_nettype wire

// File: sv/mrc_stage.sv
// One pipeline stage: four restoring-divide steps, plus the layout accumulate in a dimension's first stage.
`default_nettype none
module mrc_stage #(
  parameter int SIZE_BITS = mrc_pkg::SizeBitsDef,
  parameter bit FIRST     = 1'b0,
  parameter bit LAST      = 1'b0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           act_i,
  input  logic [mrc_pkg::DimW-1:0]                       dim_i,
  input  logic [SIZE_BITS:0]                             size_i,
  input  mrc_pkg::item_ctl_t                             ctl_i,
  input  logic [mrc_pkg::LinBits-1:0]                    q_i,
  input  logic [SIZE_BITS-1:0]                           rem_i,
  input  logic [mrc_pkg::LinBits-1:0]                    acc_i,
  input  logic [mrc_pkg::LinBits-1:0]                    prev_i,
  input  logic [mrc_pkg::MaxDims-1:0][SIZE_BITS-1:0]     crd_i,
  output mrc_pkg::item_ctl_t                             ctl_o,
  output logic [mrc_pkg::LinBits-1:0]                    q_o,
  output logic [SIZE_BITS-1:0]                           rem_o,
  output logic [mrc_pkg::LinBits-1:0]                    acc_o,
  output logic [mrc_pkg::LinBits-1:0]                    prev_o,
  output logic [mrc_pkg::MaxDims-1:0][SIZE_BITS-1:0]     crd_o
);
  import mrc_pkg::*;

  item_ctl_t                         ctl_d, ctl_q;
  logic [LinBits-1:0]                q_d, q_q;
  logic [SIZE_BITS-1:0]              rem_d, rem_q;
  logic [LinBits-1:0]                acc_d, acc_q;
  logic [LinBits-1:0]                prev_d, prev_q;
  logic [MaxDims-1:0][SIZE_BITS-1:0] crd_d, crd_q;
  logic [SIZE_BITS-1:0]              off;
  logic [SIZE_BITS:0]                part;

  always_comb begin
    off    = crd_i[dim_i];
    ctl_d  = ctl_i;
    acc_d  = acc_i;
    prev_d = prev_i;
    crd_d  = crd_i;
    // layout: add this dimension's offset times the inner product
    if (FIRST && act_i && !ctl_i.cmd) begin
      acc_d  = acc_i + prev_i * LinBits'(off);
      prev_d = prev_i * LinBits'(size_i);
      if ({1'b0, off} >= size_i) begin
        ctl_d.err = 1'b1;
      end
    end
    // unlayout: shift dividend bits out of the top of q and quotient bits in at the bottom, remainder is the digit
    rem_d = FIRST ? '0 : rem_i;
    q_d   = q_i;
    for (int j = 0; j < BitsPerStage; j++) begin
      part = {rem_d, q_d[LinBits-1]};
      q_d  = {q_d[LinBits-2:0], 1'b0};
      if (part >= size_i) begin
        part   = part - size_i;
        q_d[0] = 1'b1;
      end
      rem_d = part[SIZE_BITS-1:0];
    end
    if (LAST && act_i && ctl_i.cmd) begin
      crd_d[dim_i] = rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= q_d;
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      prev_q <= prev_d;
      crd_q  <= crd_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign q_o    = q_q;
  assign rem_o  = rem_q;
  assign acc_o  = acc_q;
  assign prev_o = prev_q;
  assign crd_o  = crd_q;

endmodule
`default_nettype wire

// File: sv/mrc_out_buf.sv
// Output register with a skid entry; formats the result item.
`default_nettype none
module mrc_out_buf #(
  parameter int SIZE_BITS = mrc_pkg::SizeBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  mrc_pkg::item_ctl_t                         ctl_i,
  input  logic [mrc_pkg::LinBits-1:0]                acc_i,
  input  logic [mrc_pkg::MaxDims-1:0][SIZE_BITS-1:0] crd_i,
  output logic                                       en_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [mrc_pkg::LinBits-1:0]                lin_o,
  output logic [mrc_pkg::MaxDims-1:0][SIZE_BITS-1:0] crd_o,
  output logic                                       err_o
);
  import mrc_pkg::*;
  `include "mixed_radix_index_convert_macros.svh"

  logic                              out_valid_d, out_valid_q;
  logic                              skid_valid_d, skid_valid_q;
  logic                              out_fire, take;
  logic                              load_out, load_skid, from_skid;
  logic [LinBits-1:0]                res_lin, out_lin_q, skid_lin_q;
  logic [MaxDims-1:0][SIZE_BITS-1:0] res_crd, out_crd_q, skid_crd_q;
  logic                              res_err, out_err_q, skid_err_q;

  assign res_lin  = ctl_i.cmd ? '0 : acc_i;
  assign res_crd  = ctl_i.cmd ? crd_i : '0;
  assign res_err  = !ctl_i.cmd && ctl_i.err;
  assign out_fire = out_valid_q && !out_stall_i;
  assign en_o     = !skid_valid_q;
  assign take     = en_o && ctl_i.valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    from_skid    = 1'b0;
    if (skid_valid_q) begin
      if (out_fire) begin
        from_skid    = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (take) begin
      if (!out_valid_q || out_fire) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        // park the item, the output is still held
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (from_skid) begin
      out_lin_q <= skid_lin_q;
      out_crd_q <= skid_crd_q;
      out_err_q <= skid_err_q;
    end else if (load_out) begin
      out_lin_q <= res_lin;
      out_crd_q <= res_crd;
      out_err_q <= res_err;
    end
    if (load_skid) begin
      skid_lin_q <= res_lin;
      skid_crd_q <= res_crd;
      skid_err_q <= res_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign lin_o       = out_lin_q;
  assign crd_o       = out_crd_q;
  assign err_o       = out_err_q;

  `MRC_ASSERT(a_skid_has_out, skid_valid_q |-> out_valid_q, "skid item without output item")
  `MRC_ASSERT(a_skid_holds, (skid_valid_q && out_stall_i) |=> skid_valid_q, "skid item dropped")
  `MRC_ASSERT(a_park_on_stall, (take && out_valid_q && out_stall_i) |=> skid_valid_q, "item lost")

endmodule
`default_nettype wire

// File: sv/mixed_radix_index_convert.sv
// Top level of the mixed-radix coordinate / linear index converter.
// Takes one item per cycle while input stall is low and returns one result per item
// through the pipeline stages and the output register. Each dimension is handled by a
// 48-bit restoring divide laid out as 12 stages of 4 quotient bits, so the
// 4 dimension steps give 48 pipeline stages, followed by the output register.
// A skid entry behind the output register lets one more item leave the
// pipeline while a result waits; input stall rises only once it is full.
// Configuration is taken every cycle (ready is always high) and must only be
// written while no item is in flight.
`default_nettype none
module mixed_radix_index_convert #(
  parameter int SIZE_BITS = mrc_pkg::SizeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mrc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [SIZE_BITS:0]          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [SIZE_BITS-1:0]        coord_in0_i,
  input  logic [SIZE_BITS-1:0]        coord_in1_i,
  input  logic [SIZE_BITS-1:0]        coord_in2_i,
  input  logic [SIZE_BITS-1:0]        coord_in3_i,
  input  logic [mrc_pkg::LinBits-1:0] linear_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrc_pkg::LinBits-1:0] linear_out_o,
  output logic [SIZE_BITS-1:0]        coord_out0_o,
  output logic [SIZE_BITS-1:0]        coord_out1_o,
  output logic [SIZE_BITS-1:0]        coord_out2_o,
  output logic [SIZE_BITS-1:0]        coord_out3_o,
  output logic                        range_error_o
);
  import mrc_pkg::*;

  localparam logic [SIZE_BITS:0] SizeMax = {1'b1, {SIZE_BITS{1'b0}}};

  logic [DimsRegW-1:0]  dims_q;
  logic [SIZE_BITS:0]   size_q [MaxDims];
  logic                 inner_q;
  logic [DimCntW-1:0]   n_dims;
  logic [SIZE_BITS:0]   eff_size [MaxDims];
  logic                 step_act [MaxDims];
  logic [DimW-1:0]      step_sel [MaxDims];
  logic [SIZE_BITS:0]   step_size [MaxDims];
  logic                 en;

  item_ctl_t                         ctl_w  [PipeDepth+1];
  logic [LinBits-1:0]                q_w    [PipeDepth+1];
  logic [SIZE_BITS-1:0]              rem_w  [PipeDepth+1];
  logic [LinBits-1:0]                acc_w  [PipeDepth+1];
  logic [LinBits-1:0]                prev_w [PipeDepth+1];
  logic [MaxDims-1:0][SIZE_BITS-1:0] crd_w  [PipeDepth+1];
  logic [MaxDims-1:0][SIZE_BITS-1:0] crd_res;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= DimsRegW'(1);
      inner_q <= 1'b1;
      for (int d = 0; d < MaxDims; d++) begin
        size_q[d] <= (SIZE_BITS+1)'(1);
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgDimsIdx) begin
        dims_q <= cfg_data_i[DimsRegW-1:0];
      end else if (cfg_index_i >= CfgSize0Idx && cfg_index_i < CfgInnerIdx) begin
        size_q[DimW'(cfg_index_i - CfgSize0Idx)] <= cfg_data_i;
      end else if (cfg_index_i == CfgInnerIdx) begin
        inner_q <= cfg_data_i[0];
      end
    end
  end

  // clamp counts and extents, map each step to its dimension
  always_comb begin
    if (dims_q == '0) begin
      n_dims = DimCntW'(1);
    end else if (32'(dims_q) > MaxDims) begin
      n_dims = DimCntW'(MaxDims);
    end else begin
      n_dims = DimCntW'(dims_q);
    end
    for (int d = 0; d < MaxDims; d++) begin
      if (size_q[d] == '0) begin
        eff_size[d] = (SIZE_BITS+1)'(1);
      end else if (size_q[d] > SizeMax) begin
        eff_size[d] = SizeMax;
      end else begin
        eff_size[d] = size_q[d];
      end
    end
    for (int k = 0; k < MaxDims; k++) begin
      step_act[k]  = 32'(n_dims) > k;
      step_sel[k]  = inner_q ? DimW'(k) : DimW'(32'(n_dims) - 1 - k);
      step_size[k] = eff_size[step_sel[k]];
    end
  end

  // pipeline entry
  assign in_stall_o  = !en;
  assign ctl_w[0]    = '{valid: in_valid_i, cmd: command_i, err: 1'b0};
  assign q_w[0]      = linear_in_i;
  assign rem_w[0]    = '0;
  assign acc_w[0]    = '0;
  assign prev_w[0]   = LinBits'(1);
  assign crd_w[0]    = command_i ? '0
                     : {coord_in3_i, coord_in2_i, coord_in1_i, coord_in0_i};

  for (genvar k = 0; k < MaxDims; k++) begin : g_dim
    for (genvar j = 0; j < StagesPerDim; j++) begin : g_stage
      localparam int S = k * StagesPerDim + j;
      mrc_stage #(
        .SIZE_BITS (SIZE_BITS),
        .FIRST     (j == 0),
        .LAST      (j == StagesPerDim - 1)
      ) u_stage (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .act_i  (step_act[k]),
        .dim_i  (step_sel[k]),
        .size_i (step_size[k]),
        .ctl_i  (ctl_w[S]),
        .q_i    (q_w[S]),
        .rem_i  (rem_w[S]),
        .acc_i  (acc_w[S]),
        .prev_i (prev_w[S]),
        .crd_i  (crd_w[S]),
        .ctl_o  (ctl_w[S+1]),
        .q_o    (q_w[S+1]),
        .rem_o  (rem_w[S+1]),
        .acc_o  (acc_w[S+1]),
        .prev_o (prev_w[S+1]),
        .crd_o  (crd_w[S+1])
      );
    end
  end

  mrc_out_buf #(
    .SIZE_BITS (SIZE_BITS)
  ) u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_w[PipeDepth]),
    .acc_i       (acc_w[PipeDepth]),
    .crd_i       (crd_w[PipeDepth]),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lin_o       (linear_out_o),
    .crd_o       (crd_res),
    .err_o       (range_error_o)
  );

  assign coord_out0_o = crd_res[0];
  assign coord_out1_o = crd_res[1];
  assign coord_out2_o = crd_res[2];
  assign coord_out3_o = crd_res[3];

endmodule
`default_nettype wire

// File: verif/mixed_radix_index_convert_tb.sv
// Testbench for the mixed-radix index converter: predicted results, directed and random traffic.
`timescale 1ns / 100ps
`default_nettype none
module mixed_radix_index_convert_tb;
  import mrc_pkg::*;

  localparam int SizeBits = SizeBitsDef;
  localparam int Latency = 49;
  localparam logic CmdLayout = 1'b0;
  localparam logic CmdUnlayout = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSize1Idx = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSize2Idx = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgSize3Idx = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = CfgIdxW'(MaxDims + 2);

  typedef logic [SizeBits-1:0] coord_t;
  typedef logic [LinBits-1:0] lin_t;

  typedef struct packed {
    lin_t linear;
    coord_t c0, c1, c2, c3;
    logic err;
  } index_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SizeBits:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  coord_t coord_in0_i = '0, coord_in1_i = '0, coord_in2_i = '0, coord_in3_i = '0;
  lin_t linear_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lin_t linear_out_o;
  coord_t coord_out0_o, coord_out1_o, coord_out2_o, coord_out3_o;
  logic range_error_o;

  mixed_radix_index_convert #(.SIZE_BITS(SizeBits)) dut (.*);

  always #1 clk_i = ~clk_i;

  // configuration copy kept by the predictor
  logic [2:0] dims_reg = 3'd1;
  logic [SizeBits:0] extent_reg [MaxDims] = '{default: 1};
  logic inner_reg = 1'b1;

  index_result_t pending_results[$];
  int errors = 0;
  int hold_cycles = 0;
  bit stall_on = 1'b1;
  longint unsigned cycles = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic index_result_t convert_index(logic cmd, coord_t ci[MaxDims], lin_t lin);
    index_result_t r;
    int n, d;
    longint unsigned sz, prev, acc, q;
    coord_t co[MaxDims];
    bit big;
    r = '0;
    co = '{default: '0};
    n = int'(dims_reg);
    if (n < 1) n = 1;
    if (n > MaxDims) n = MaxDims;
    prev = 1;
    acc = 0;
    big = 0;
    for (int k = 0; k < n; k++) begin
      d = inner_reg ? k : n - 1 - k;
      sz = 64'(extent_reg[d]);
      if (sz < 1) sz = 1;
      if (sz > (64'd1 << SizeBits)) sz = 64'd1 << SizeBits;
      if (cmd == CmdLayout) begin
        if (64'(ci[d]) >= sz) r.err = 1'b1;
        acc += 64'(ci[d]) * prev;
        prev *= sz;
      end else begin
        q = big ? 0 : 64'(lin) / prev;
        co[d] = coord_t'(q % sz);
        if (!big) begin
          if (prev > ((64'd1 << LinBits) - 1) / sz) big = 1;
          else prev *= sz;
        end
      end
    end
    if (cmd == CmdLayout) r.linear = lin_t'(acc);
    r.c0 = co[0]; r.c1 = co[1]; r.c2 = co[2]; r.c3 = co[3];
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[SizeBits:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgDimsIdx) dims_reg = val[2:0];
    else if (idx >= CfgSize0Idx && idx < CfgInnerIdx) extent_reg[idx - 1] = val[SizeBits:0];
    else if (idx == CfgInnerIdx) inner_reg = val[0];
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic setup(int unsigned dims, int unsigned s0, int unsigned s1, int unsigned s2,
                       int unsigned s3, int unsigned inner);
    drain();
    write_reg(CfgDimsIdx, dims);
    write_reg(CfgSize0Idx, s0);
    write_reg(CfgSize1Idx, s1);
    write_reg(CfgSize2Idx, s2);
    write_reg(CfgSize3Idx, s3);
    write_reg(CfgInnerIdx, inner);
  endtask

  task automatic send_item(logic cmd, coord_t a, coord_t b, coord_t c, coord_t d, lin_t lin,
                           bit gaps = 1);
    coord_t ci[MaxDims];
    int g;
    g = gaps ? idle_len() : 0;
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    coord_in0_i <= a; coord_in1_i <= b; coord_in2_i <= c; coord_in3_i <= d;
    linear_in_i <= lin;
    ci = '{a, b, c, d};
    do @(posedge clk_i); while (in_stall_o);
    pending_results = {pending_results, convert_index(cmd, ci, lin)};
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic lin_t rnd_lin();
    case ($urandom_range(0, 3))
      0: return lin_t'($urandom_range(0, 5000));
      1: return '1;
      default: return lin_t'({$urandom, $urandom});
    endcase
  endfunction

  // coordinates mostly inside the configured extents
  function automatic coord_t fit_coord(int d);
    int unsigned sz;
    sz = 32'(extent_reg[d]);
    if (sz < 1) sz = 1;
    if (sz > 4096) sz = 4096;
    if ($urandom_range(0, 9) == 0) return rnd_coord();
    return coord_t'($urandom_range(0, sz - 1));
  endfunction

  task automatic test_reset_defaults();
    send_item(CmdLayout, 0, 0, 0, 0, 0);
    send_item(CmdLayout, 1, 5, 6, 7, '1);
    send_item(CmdUnlayout, '1, '1, '1, '1, '1);
    end_burst();
  endtask

  task automatic test_directed();
    setup(4, 4096, 4096, 4096, 4096, 1);
    send_item(CmdLayout, '1, '1, '1, '1, 0);
    send_item(CmdLayout, 0, 0, 0, 0, '1);
    send_item(CmdUnlayout, 0, 0, 0, 0, '1);
    send_item(CmdUnlayout, '1, '1, '1, '1, 48'h123456789abc);
    end_burst();
    // out-of-range extents and counts
    setup(7, 0, 8191, 3, 5, 0);
    send_item(CmdLayout, 0, 4095, 2, 4, 0);
    send_item(CmdLayout, 1, 0, 3, 5, 0);
    send_item(CmdUnlayout, 0, 0, 0, 0, 48'd777);
    end_burst();
    setup(0, 10, 20, 30, 40, 1);
    send_item(CmdLayout, 9, 19, 29, 39, 0);
    send_item(CmdLayout, 10, 0, 0, 0, 0);
    send_item(CmdUnlayout, 0, 0, 0, 0, 48'd12345);
    end_burst();
    drain();
    write_reg(CfgSpareIdx, 8191);
    setup(3, 4095, 4095, 2, 7, 0);
    send_item(CmdLayout, 4094, 4094, 1, 6, 0);
    send_item(CmdUnlayout, 0, 0, 0, 0, '1);
    send_item(CmdUnlayout, 0, 0, 0, 0, 48'd4095);
    end_burst();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 75 == 0) begin
        end_burst();
        if ($urandom_range(0, 2) == 0)
          setup($urandom_range(0, 7), $urandom_range(0, 8191), $urandom_range(0, 8191),
                $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 1));
        else
          setup($urandom_range(1, 4), $urandom_range(1, 64), $urandom_range(1, 4096),
                $urandom_range(1, 16), $urandom_range(1, 300), $urandom_range(0, 1));
      end
      if ($urandom_range(0, 1) == 0)
        send_item(CmdLayout, fit_coord(0), fit_coord(1), fit_coord(2), fit_coord(3), rnd_lin());
      else
        send_item(CmdUnlayout, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_lin());
    end
    end_burst();
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    for (int i = 0; i < 80; i++)
      send_item(command_i ^ 1'b1, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                rnd_lin(), 0);
    end_burst();
    drain();
  endtask

  // receiver: random stalls, or one long hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_on) begin
      out_stall_i <= ($urandom_range(0, 99) < 25);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    index_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (linear_out_o !== exp_r.linear) begin
          $error("linear_out exp %0h got %0h", exp_r.linear, linear_out_o); errors++;
        end
        if (coord_out0_o !== exp_r.c0) begin
          $error("coord_out0 exp %0d got %0d", exp_r.c0, coord_out0_o); errors++;
        end
        if (coord_out1_o !== exp_r.c1) begin
          $error("coord_out1 exp %0d got %0d", exp_r.c1, coord_out1_o); errors++;
        end
        if (coord_out2_o !== exp_r.c2) begin
          $error("coord_out2 exp %0d got %0d", exp_r.c2, coord_out2_o); errors++;
        end
        if (coord_out3_o !== exp_r.c3) begin
          $error("coord_out3 exp %0d got %0d", exp_r.c3, coord_out3_o); errors++;
        end
        if (range_error_o !== exp_r.err) begin
          $error("range_error exp %0d got %0d", exp_r.err, range_error_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("mixed_radix_index_convert_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random(200);
    test_backpressure();
    stall_on = 1'b0;
    test_random(60);
    stall_on = 1'b1;
    test_random(110);
    drain();
    if (errors == 0 && pending_results.size() == 0)
      $display("mixed_radix_index_convert_tb OK");
    else
      $display("mixed_radix_index_convert_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
